/* hdl/olex_pkg.sv */
// ----------------------------------------------------------------------------
// olex_pkg
// Shared types and token codes for the operator, number and identifier lexer.
// ----------------------------------------------------------------------------
package olex_pkg;

	// widths of the line and column counters
	localparam int LINE_BITS   = 24;
	localparam int COLUMN_BITS = 16;

	// token kinds
	localparam logic [4:0] K_ENDL   = 5'd0;
	localparam logic [4:0] K_LT     = 5'd1;
	localparam logic [4:0] K_GT     = 5'd2;
	localparam logic [4:0] K_LPAR   = 5'd3;
	localparam logic [4:0] K_RPAR   = 5'd4;
	localparam logic [4:0] K_LBRK   = 5'd5;
	localparam logic [4:0] K_RBRK   = 5'd6;
	localparam logic [4:0] K_DOT    = 5'd7;
	localparam logic [4:0] K_COMMA  = 5'd8;
	localparam logic [4:0] K_ADD    = 5'd9;
	localparam logic [4:0] K_SUB    = 5'd10;
	localparam logic [4:0] K_MUL    = 5'd11;
	localparam logic [4:0] K_DIV    = 5'd12;
	localparam logic [4:0] K_IADD   = 5'd13;
	localparam logic [4:0] K_ISUB   = 5'd14;
	localparam logic [4:0] K_IMUL   = 5'd15;
	localparam logic [4:0] K_IDIV   = 5'd16;
	localparam logic [4:0] K_ASSIGN = 5'd17;
	localparam logic [4:0] K_EQ     = 5'd18;
	localparam logic [4:0] K_NE     = 5'd19;
	localparam logic [4:0] K_GE     = 5'd20;
	localparam logic [4:0] K_LE     = 5'd21;
	localparam logic [4:0] K_INT    = 5'd22;
	localparam logic [4:0] K_DEC    = 5'd23;
	localparam logic [4:0] K_STR    = 5'd24;
	localparam logic [4:0] K_IDN    = 5'd25;
	localparam logic [4:0] K_TEXT   = 5'd26;
	localparam logic [4:0] K_ERR    = 5'd27;

	// error codes
	localparam logic [2:0] E_NONE     = 3'd0;
	localparam logic [2:0] E_BANG     = 3'd1;
	localparam logic [2:0] E_OPEN_STR = 3'd2;
	localparam logic [2:0] E_LONG_STR = 3'd3;
	localparam logic [2:0] E_LONG_ID  = 3'd4;
	localparam logic [2:0] E_BAD_CHAR = 3'd5;
	localparam logic [2:0] E_BAD_NUM  = 3'd6;

	localparam int unsigned MAX_RES = 3;

	typedef struct packed {
		logic [4:0]             kind;
		logic [LINE_BITS-1:0]   line;
		logic [COLUMN_BITS-1:0] column;
		logic signed [63:0]     value;
		logic signed [10:0]     expo;
		logic [7:0]             ch;
		logic [8:0]             len;
		logic [2:0]             err;
		logic                   last;
	} result_t;

endpackage

/* hdl/olex_core.sv */
// ----------------------------------------------------------------------------
// olex_core
// Lexer state and the combinational step that turns one byte into up to three
// results.
// ----------------------------------------------------------------------------
module olex_core #(
	parameter int IDENT_MAX   = 64,
	parameter int STRING_MAX  = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic [7:0]           in_byte,
	input  logic                 end_of_buffer,
	output olex_pkg::result_t    res [olex_pkg::MAX_RES],
	output logic [1:0]           res_count
);
	import olex_pkg::*;

	localparam int TMAX      = (IDENT_MAX > STRING_MAX) ? IDENT_MAX : STRING_MAX;
	localparam int TCNT_BITS = $clog2(TMAX + 1);
	localparam logic [10:0] ACC_MAX = 11'd2047;

	typedef enum logic [3:0] {
		M_IDLE, M_OP, M_MINUS, M_MINUS_DOT, M_INT, M_FRAC,
		M_EXP_START, M_EXP_DIGITS, M_STRING, M_IDENT, M_ERROR
	} mode_t;

	typedef struct packed {
		mode_t                  mode;
		logic [7:0]             pend;
		logic [LINE_BITS-1:0]   line_cnt;
		logic [COLUMN_BITS-1:0] col_cnt;
		logic [LINE_BITS-1:0]   tok_line;
		logic [COLUMN_BITS-1:0] tok_col;
		logic [63:0]            sig;
		logic                   neg;
		logic [10:0]            frac;
		logic [10:0]            expa;
		logic                   expneg;
		logic [TCNT_BITS-1:0]   tcnt;
		logic                   err_hold;
	} lex_t;

	typedef struct packed {
		lex_t    st;
		logic    emit;
		result_t r;
		logic    redo;
	} pass_t;

	lex_t st_q, st_next;

	function automatic lex_t reset_state();
		lex_t s;
		s          = '0;
		s.mode     = M_IDLE;
		s.line_cnt = LINE_BITS'(1);
		s.tok_line = LINE_BITS'(1);
		return s;
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_id_start(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic result_t mk(lex_t s, logic [4:0] kind, logic [63:0] value,
			logic [10:0] expo, logic [7:0] ch, logic [2:0] err);
		result_t r;
		r.kind   = kind;
		r.line   = s.tok_line;
		r.column = s.tok_col;
		r.value  = value;
		r.expo   = expo;
		r.ch     = ch;
		r.len    = 9'(s.tcnt);
		r.err    = err;
		r.last   = 1'b0;
		if (kind != K_STR && kind != K_IDN) r.len = '0;
		return r;
	endfunction

	function automatic logic [4:0] op_single(logic [7:0] c);
		case (c)
			"<":     return K_LT;
			">":     return K_GT;
			"+":     return K_ADD;
			"*":     return K_MUL;
			"/":     return K_DIV;
			default: return K_ASSIGN;
		endcase
	endfunction

	function automatic logic [4:0] op_pair(logic [7:0] c);
		case (c)
			"<":     return K_LE;
			">":     return K_GE;
			"+":     return K_IADD;
			"*":     return K_IMUL;
			"/":     return K_IDIV;
			"!":     return K_NE;
			default: return K_EQ;
		endcase
	endfunction

	function automatic logic [63:0] add_digit(logic [63:0] v, logic [7:0] c);
		return (v << 3) + (v << 1) + {60'd0, c[3:0]};
	endfunction

	// close an integer or decimal token
	function automatic result_t finish_num(lex_t s);
		logic [63:0]        v;
		logic signed [12:0] e;
		logic [10:0]        eo;
		v  = s.neg ? (64'd0 - s.sig) : s.sig;
		e  = s.expneg ? -$signed({2'b00, s.expa}) : $signed({2'b00, s.expa});
		e  = e - $signed({2'b00, s.frac});
		if (e > 13'sd1023)       eo = 11'sd1023;
		else if (e < -13'sd1023) eo = -11'sd1023;
		else                     eo = e[10:0];
		if (s.mode == M_INT) return mk(s, K_INT, v, '0, '0, E_NONE);
		return mk(s, K_DEC, v, eo, '0, E_NONE);
	endfunction

	// one pass of the lexer over a byte; may ask for the byte again
	function automatic pass_t step(lex_t s, logic [7:0] c, logic [COLUMN_BITS-1:0] col);
		pass_t       p;
		logic [14:0] en;
		p.st   = s;
		p.emit = 1'b0;
		p.r    = '0;
		p.redo = 1'b0;
		en     = 15'({4'd0, s.expa} * 15'd10) + {11'd0, c[3:0]};
		case (s.mode)
			M_OP: begin
				p.emit = 1'b1;
				if (c == "=") begin
					p.r       = mk(s, op_pair(s.pend), '0, '0, '0, E_NONE);
					p.st.mode = M_IDLE;
				end else if (s.pend == "!") begin
					p.r           = mk(s, K_ERR, '0, '0, '0, E_BANG);
					p.st.mode     = M_ERROR;
					p.st.err_hold = 1'b1;
				end else begin
					p.r       = mk(s, op_single(s.pend), '0, '0, '0, E_NONE);
					p.st.mode = M_IDLE;
					p.redo    = 1'b1;
				end
			end
			M_MINUS: begin
				if (c == "=") begin
					p.emit    = 1'b1;
					p.r       = mk(s, K_ISUB, '0, '0, '0, E_NONE);
					p.st.mode = M_IDLE;
				end else if (is_digit(c)) begin
					p.st.neg  = 1'b1;
					p.st.sig  = add_digit(s.sig, c);
					p.st.mode = M_INT;
				end else if (c == ".") begin
					p.st.neg  = 1'b1;
					p.st.mode = M_MINUS_DOT;
				end else begin
					p.emit    = 1'b1;
					p.r       = mk(s, K_SUB, '0, '0, '0, E_NONE);
					p.st.mode = M_IDLE;
					p.redo    = 1'b1;
				end
			end
			M_MINUS_DOT: begin
				if (is_digit(c)) begin
					p.st.sig  = add_digit(s.sig, c);
					p.st.frac = 11'd1;
					p.st.mode = M_FRAC;
				end else if (is_id_start(c)) begin
					p.emit    = 1'b1;
					p.r       = mk(s, K_TEXT, '0, '0, c, E_NONE);
					p.st.tcnt = TCNT_BITS'(1);
					p.st.mode = M_IDENT;
				end else begin
					p.emit        = 1'b1;
					p.r           = mk(s, K_ERR, '0, '0, '0, E_BAD_CHAR);
					p.st.mode     = M_ERROR;
					p.st.err_hold = 1'b1;
				end
			end
			M_INT, M_FRAC: begin
				if (is_digit(c)) begin
					p.st.sig = add_digit(s.sig, c);
					if (s.mode == M_FRAC && s.frac < ACC_MAX) p.st.frac = s.frac + 11'd1;
				end else if (c == "." && s.mode == M_INT) begin
					p.st.mode = M_FRAC;
				end else if (c == "e" || c == "E") begin
					p.st.mode = M_EXP_START;
				end else begin
					p.emit    = 1'b1;
					p.r       = finish_num(s);
					p.st.mode = M_IDLE;
					p.redo    = 1'b1;
				end
			end
			M_EXP_START, M_EXP_DIGITS: begin
				if (c == "-" && s.mode == M_EXP_START) begin
					p.st.expneg = 1'b1;
					p.st.mode   = M_EXP_DIGITS;
				end else if (is_digit(c)) begin
					p.st.expa = (en > 15'd2047) ? ACC_MAX : en[10:0];
					p.st.mode = M_EXP_DIGITS;
				end else begin
					p.emit    = 1'b1;
					p.r       = finish_num(s);
					p.st.mode = M_IDLE;
					p.redo    = 1'b1;
				end
			end
			M_STRING: begin
				p.emit = 1'b1;
				if (c == "\"") begin
					p.r       = mk(s, K_STR, '0, '0, '0, E_NONE);
					p.st.mode = M_IDLE;
				end else if (32'(s.tcnt) >= STRING_MAX) begin
					p.r           = mk(s, K_ERR, '0, '0, '0, E_LONG_STR);
					p.st.mode     = M_ERROR;
					p.st.err_hold = 1'b1;
				end else begin
					p.r       = mk(s, K_TEXT, '0, '0, c, E_NONE);
					p.st.tcnt = s.tcnt + TCNT_BITS'(1);
				end
			end
			M_IDENT: begin
				p.emit = 1'b1;
				if (is_digit(c) || is_id_start(c)) begin
					if (32'(s.tcnt) >= IDENT_MAX) begin
						p.r           = mk(s, K_ERR, '0, '0, '0, E_LONG_ID);
						p.st.mode     = M_ERROR;
						p.st.err_hold = 1'b1;
					end else begin
						p.r       = mk(s, K_TEXT, '0, '0, c, E_NONE);
						p.st.tcnt = s.tcnt + TCNT_BITS'(1);
					end
				end else begin
					p.r       = mk(s, K_IDN, '0, '0, '0, E_NONE);
					p.st.mode = M_IDLE;
					p.redo    = 1'b1;
				end
			end
			M_IDLE: begin
				p.st.tok_line = s.line_cnt;
				p.st.tok_col  = col;
				case (c)
					" ", "\t", 8'h0d, 8'h0b, 8'h0c: begin
					end
					"\n": begin
						if (s.line_cnt != '1) p.st.line_cnt = s.line_cnt + LINE_BITS'(1);
						p.st.col_cnt  = '0;
						p.st.tok_line = p.st.line_cnt;
						p.st.tok_col  = '0;
						p.emit        = 1'b1;
						p.r           = mk(p.st, K_ENDL, '0, '0, '0, E_NONE);
					end
					"(": begin p.emit = 1'b1; p.r = mk(p.st, K_LPAR, '0, '0, '0, E_NONE); end
					")": begin p.emit = 1'b1; p.r = mk(p.st, K_RPAR, '0, '0, '0, E_NONE); end
					"[": begin p.emit = 1'b1; p.r = mk(p.st, K_LBRK, '0, '0, '0, E_NONE); end
					"]": begin p.emit = 1'b1; p.r = mk(p.st, K_RBRK, '0, '0, '0, E_NONE); end
					".": begin p.emit = 1'b1; p.r = mk(p.st, K_DOT, '0, '0, '0, E_NONE); end
					",": begin p.emit = 1'b1; p.r = mk(p.st, K_COMMA, '0, '0, '0, E_NONE); end
					"<", ">", "+", "*", "/", "!", "=": begin
						p.st.pend = c;
						p.st.mode = M_OP;
					end
					"-": begin
						p.st.sig    = '0;
						p.st.neg    = 1'b0;
						p.st.frac   = '0;
						p.st.expa   = '0;
						p.st.expneg = 1'b0;
						p.st.mode   = M_MINUS;
					end
					"\"": begin
						p.st.tcnt = '0;
						p.st.mode = M_STRING;
					end
					default: begin
						p.emit = 1'b1;
						if (is_digit(c)) begin
							p.emit      = 1'b0;
							p.st.sig    = {60'd0, c[3:0]};
							p.st.neg    = 1'b0;
							p.st.frac   = '0;
							p.st.expa   = '0;
							p.st.expneg = 1'b0;
							p.st.mode   = M_INT;
						end else if (is_id_start(c)) begin
							p.st.tcnt = TCNT_BITS'(1);
							p.r       = mk(p.st, K_TEXT, '0, '0, c, E_NONE);
							p.st.mode = M_IDENT;
						end else begin
							p.r           = mk(p.st, K_ERR, '0, '0, '0, E_BAD_CHAR);
							p.st.mode     = M_ERROR;
							p.st.err_hold = 1'b1;
						end
					end
				endcase
			end
			default: begin
			end
		endcase
		return p;
	endfunction

	// end of buffer: close whatever token is open
	function automatic pass_t flush(lex_t s);
		pass_t p;
		p.st   = s;
		p.emit = 1'b1;
		p.redo = 1'b0;
		p.r    = '0;
		case (s.mode)
			M_OP:
				if (s.pend == "!") p.r = mk(s, K_ERR, '0, '0, '0, E_BANG);
				else               p.r = mk(s, op_single(s.pend), '0, '0, '0, E_NONE);
			M_MINUS:     p.r = mk(s, K_SUB, '0, '0, '0, E_NONE);
			M_MINUS_DOT: p.r = mk(s, K_ERR, '0, '0, '0, E_BAD_NUM);
			M_INT, M_FRAC, M_EXP_START, M_EXP_DIGITS: p.r = finish_num(s);
			M_STRING:    p.r = mk(s, K_ERR, '0, '0, '0, E_OPEN_STR);
			M_IDENT:     p.r = mk(s, K_IDN, '0, '0, '0, E_NONE);
			default:     p.emit = 1'b0;
		endcase
		return p;
	endfunction

	pass_t p1, p2, pf;

	always_comb begin
		lex_t              s;
		result_t           r [MAX_RES];
		logic [1:0]        n;
		p1 = step(st_q, in_byte, st_q.col_cnt);
		p2 = step(p1.st, in_byte, st_q.col_cnt);
		for (int i = 0; i < MAX_RES; i++) r[i] = '0;
		n = 2'd0;
		s = st_q;
		if (!st_q.err_hold && st_q.mode != M_ERROR) begin
			s = p1.st;
			if (p1.emit) begin
				r[n] = p1.r;
				n    = n + 2'd1;
			end
			if (p1.redo) begin
				s = p2.st;
				if (p2.emit) begin
					r[n] = p2.r;
					n    = n + 2'd1;
				end
			end
		end
		if (s.col_cnt != '1) s.col_cnt = s.col_cnt + COLUMN_BITS'(1);
		pf = flush(s);
		if (end_of_buffer) begin
			if (pf.emit) begin
				r[n] = pf.r;
				n    = n + 2'd1;
			end
			s = reset_state();
		end
		if (n != 2'd0) r[n - 2'd1].last = 1'b1;
		res       = r;
		res_count = n;
		st_next   = s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= reset_state();
		else if (fire) st_q <= st_next;
	end

endmodule

/* hdl/olex_outq.sv */
// ----------------------------------------------------------------------------
// olex_outq
// Four-entry result queue: takes up to three results in a cycle, gives one.
// ----------------------------------------------------------------------------
module olex_outq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [1:0]           push_count,
	input  olex_pkg::result_t    push_res [olex_pkg::MAX_RES],
	input  logic                 pop,
	output logic                 head_valid,
	output olex_pkg::result_t    head,
	output logic                 room
);
	import olex_pkg::*;

	result_t    entry_q [4];
	logic [1:0] rd_q, wr_q;
	logic [2:0] cnt_q;
	logic [2:0] add;

	assign head_valid = cnt_q != 3'd0;
	assign head       = entry_q[rd_q];
	// room for three more once this cycle's pop leaves
	assign room       = (cnt_q - {2'b00, pop}) <= 3'd1;
	assign add        = push ? {1'b0, push_count} : 3'd0;

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++)
			if (push && 2'(i) < push_count) entry_q[wr_q + 2'(i)] <= push_res[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			rd_q  <= rd_q + {1'b0, pop};
			wr_q  <= wr_q + add[1:0];
			cnt_q <= cnt_q + add - {2'b00, pop};
		end
	end

endmodule

/* hdl/operator_number_identifier_lexer.sv */
// ----------------------------------------------------------------------------
// operator_number_identifier_lexer
// Streaming lexer: one source byte per item in, tokens with line and column out.
// ----------------------------------------------------------------------------
//  channel | signals                                   | accepted when
//  --------+-------------------------------------------+-----------------------
//  input   | in_valid, in_stall, in_byte, end_of_buffer| in_valid & !in_stall
//  output  | out_valid, out_stall, token fields        | out_valid & !out_stall
//
// An accepted byte sits in the input register, where the lexer step runs and
// writes zero to three results into a four-entry queue. Results leave at one
// per cycle when not stalled, so a byte is taken every cycle while each byte
// makes at most one result; bytes that make more throttle input to the queue
// drain. Reset puts the lexer between tokens at line 1, column 0, queue empty.
// Hold the input register whenever the queue cannot take three more results.
// ----------------------------------------------------------------------------
module operator_number_identifier_lexer #(
	parameter int IDENT_MAX   = 64,
	parameter int STRING_MAX  = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         in_byte,
	input  logic               end_of_buffer,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [4:0]         token_kind,
	output logic [23:0]        line_number,
	output logic [15:0]        column_number,
	output logic signed [63:0] number_value,
	output logic signed [10:0] decimal_exponent,
	output logic [7:0]         text_char,
	output logic [8:0]         text_length,
	output logic [2:0]         error_code,
	output logic               last_of_run
);
	import olex_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eob_s1;
	logic       fire, room, pop;
	result_t    res [MAX_RES];
	logic [1:0] res_count;
	result_t    head;

	// the step fires once the queue has room for the worst case
	assign fire     = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign pop      = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (!in_stall) valid_s1 <= in_valid;
	end

	// advance payload only on acceptance
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
			eob_s1  <= end_of_buffer;
		end
	end

	olex_core #(
		.IDENT_MAX  (IDENT_MAX),
		.STRING_MAX (STRING_MAX)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.in_byte      (byte_s1),
		.end_of_buffer(eob_s1),
		.res          (res),
		.res_count    (res_count)
	);

	olex_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire),
		.push_count(res_count),
		.push_res  (res),
		.pop       (pop),
		.head_valid(out_valid),
		.head      (head),
		.room      (room)
	);

	assign token_kind       = head.kind;
	assign line_number      = head.line;
	assign column_number    = head.column;
	assign number_value     = head.value;
	assign decimal_exponent = head.expo;
	assign text_char        = head.ch;
	assign text_length      = head.len;
	assign error_code       = head.err;
	assign last_of_run      = head.last;

endmodule
